// ===== design/sipu_pkg.sv =====
// Shared widths, codes and payload types of the segment intersection point unit.
// No dependencies; imported by the top level and referenced by the divider defaults.
`default_nettype none

package sipu_pkg;

   localparam int LON_W      = 31;
   localparam int LAT_W      = 30;
   localparam int DX_W       = 32;
   localparam int DY_W       = 31;
   localparam int N_W        = 64;
   localparam int HALF_N_W   = N_W / 2;
   localparam int QUO_W      = 32;
   localparam int NUM1_W     = 97;
   localparam int DEN1_W     = 64;
   localparam int NUM2_W     = 64;
   localparam int DEN2_W     = 32;
   localparam int X_W        = QUO_W + 1;
   localparam int OUT_W      = 2;
   localparam int REQ_DATA_W = 248;
   localparam int RSP_DATA_W = 64;

   typedef logic signed [LON_W-1:0] lon_type;
   typedef logic signed [LAT_W-1:0] lat_type;
   typedef logic signed [DX_W-1:0]  dx_type;
   typedef logic signed [DY_W-1:0]  dy_type;
   typedef logic signed [N_W-1:0]   n_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_NONE  = 2'd0,
      OUT_CROSS = 2'd1,
      OUT_COINC = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      MODE_MISS,
      MODE_COINC,
      MODE_VERT,
      MODE_PARALLEL,
      MODE_GENERAL
   } mode_type;

   typedef struct packed {
      lon_type a_lo;
      lon_type a_hi;
      lon_type b_lo;
      lon_type b_hi;
   } xbox_type;

   typedef struct packed {
      lat_type a_lo;
      lat_type a_hi;
      lat_type b_lo;
      lat_type b_hi;
   } ybox_type;

   // sideband through the x divider
   typedef struct packed {
      xbox_type xbox;
      ybox_type ybox;
      mode_type mode;
      lon_type  xv;
      dy_type   dys;
      n_type    ns;
      dx_type   dxs;
      logic     neg;
   } side1_type;

   // sideband through the y divider
   typedef struct packed {
      ybox_type ybox;
      mode_type mode;
      lon_type  x;
      logic     xin;
      logic     neg;
   } side2_type;

endpackage

`default_nettype wire

// ===== design/sipu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag and sideband.
// Width defaults come from sipu_pkg.
`default_nettype none

module sipu_div #(
   parameter int NUM_W  = sipu_pkg::NUM1_W,
   parameter int DEN_W  = sipu_pkg::DEN1_W,
   parameter int QUO_W  = sipu_pkg::QUO_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_q,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   localparam int REM_W = DEN_W + 1;

   logic              v_ff    [0:QUO_W];
   logic [DEN_W-1:0]  rem_ff  [0:QUO_W];
   logic [DEN_W-1:0]  den_ff  [0:QUO_W];
   logic [QUO_W-1:0]  low_ff  [0:QUO_W];
   logic [QUO_W-1:0]  q_ff    [0:QUO_W];
   logic              ovf_ff  [0:QUO_W];
   logic [SIDE_W-1:0] side_ff [0:QUO_W];

   logic [REM_W-1:0] top_in;
   logic             ovf_in;

   // quotient fits in QUO_W bits only if the upper part is below the divisor
   always_comb begin
      top_in = REM_W'(in_num >> QUO_W);
      ovf_in = top_in >= REM_W'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ce) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0]  <= ovf_in ? '0 : top_in[DEN_W-1:0];
         den_ff[0]  <= in_den;
         low_ff[0]  <= in_num[QUO_W-1:0];
         q_ff[0]    <= '0;
         ovf_ff[0]  <= ovf_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] diff;
      logic             ge;

      always_comb begin
         sh   = {rem_ff[k], low_ff[k][QUO_W-1]};
         diff = sh - {1'b0, den_ff[k]};
         ge   = sh >= {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (ce) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[k+1]  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
            den_ff[k+1]  <= den_ff[k];
            low_ff[k+1]  <= {low_ff[k][QUO_W-2:0], 1'b0};
            q_ff[k+1]    <= {q_ff[k][QUO_W-2:0], ge};
            ovf_ff[k+1]  <= ovf_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign out_q     = q_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

`default_nettype wire

// ===== design/segment_intersection_point_unit.sv =====
// Top level of the segment intersection point unit: stream ports and arithmetic pipeline.
// Depends on sipu_pkg and sipu_div (two instances, x quotient and y quotient).
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | req_tdata: two segments, eight coordinates
//   rsp     | out | rsp_tvalid/tready    | rsp_tdata: crossing lat/lon, rsp_tuser: outcome
//
// One transaction enters per cycle unless a result is held on rsp; each leaves as one result.
// The pipeline holds the two bit-per-stage dividers (33 stages each) plus 13 arithmetic stages.
// Reset is synchronous and clears all valid bits; payload registers are not reset.
// A result held on rsp stalls the whole pipeline in place; nothing is dropped or repeated.
`default_nettype none

module segment_intersection_point_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // a_start_lon, a_start_lat, a_end_lon, a_end_lat,
   // b_start_lon, b_start_lat, b_end_lon, b_end_lat, zero pad
   input  logic [sipu_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cross_lat, cross_lon, zero pad
   output logic [sipu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // outcome
   output logic [sipu_pkg::OUT_W-1:0]      rsp_tuser
);

   import sipu_pkg::*;

   localparam int SIDE1_W = $bits(side1_type);
   localparam int SIDE2_W = $bits(side2_type);
   localparam int PAD_W   = RSP_DATA_W - LAT_W - LON_W;

   typedef struct packed {
      lon_type ax0;
      lat_type ay0;
      lon_type ax1;
      lat_type ay1;
      lon_type bx0;
      lat_type by0;
      lon_type bx1;
      lat_type by1;
   } s0_type;

   typedef struct packed {
      xbox_type xbox;
      ybox_type ybox;
      dx_type   dxa;
      dx_type   dxb;
      dy_type   dya;
      dy_type   dyb;
      lon_type  ax0;
      lon_type  bx0;
      lon_type  ax1;
      lon_type  bx1;
      lat_type  ay0;
      lat_type  by0;
      logic     va;
      logic     vb;
   } s1_type;

   typedef struct packed {
      xbox_type           xbox;
      ybox_type           ybox;
      dx_type             dxa;
      dx_type             dxb;
      dy_type             dya;
      dy_type             dyb;
      lon_type            ax1;
      lon_type            bx1;
      logic               va;
      logic               vb;
      logic signed [61:0] pa1;
      logic signed [61:0] pa2;
      logic signed [61:0] pb1;
      logic signed [61:0] pb2;
      logic signed [62:0] psa;
      logic signed [62:0] psb;
   } s2_type;

   typedef struct packed {
      xbox_type xbox;
      ybox_type ybox;
      mode_type mode;
      lon_type  xv;
      dy_type   dys;
      n_type    ns;
      dx_type   dxs;
      dx_type   dxa;
      dx_type   dxb;
      n_type    na;
      n_type    nb;
      n_type    den;
   } s3_type;

   typedef struct packed {
      xbox_type           xbox;
      ybox_type           ybox;
      mode_type           mode;
      lon_type            xv;
      dy_type             dys;
      n_type              ns;
      dx_type             dxs;
      n_type              den;
      logic signed [63:0] pbh;
      logic signed [64:0] pbl;
      logic signed [63:0] pah;
      logic signed [64:0] pal;
   } s4_type;

   typedef struct packed {
      xbox_type                  xbox;
      ybox_type                  ybox;
      mode_type                  mode;
      lon_type                   xv;
      dy_type                    dys;
      n_type                     ns;
      dx_type                    dxs;
      n_type                     den;
      logic signed [NUM1_W-1:0]  nbdxa;
      logic signed [NUM1_W-1:0]  nadxb;
   } s5_type;

   typedef struct packed {
      xbox_type                  xbox;
      ybox_type                  ybox;
      mode_type                  mode;
      lon_type                   xv;
      dy_type                    dys;
      n_type                     ns;
      dx_type                    dxs;
      n_type                     den;
      logic signed [NUM1_W-1:0]  num;
   } s6_type;

   typedef struct packed {
      logic [NUM1_W-1:0] num_mag;
      logic [DEN1_W-1:0] den_mag;
      side1_type         side;
   } s7_type;

   typedef struct packed {
      ybox_type             ybox;
      mode_type             mode;
      logic signed [X_W-1:0] x;
      logic                 xin;
      dy_type               dys;
      n_type                ns;
      dx_type               dxs;
   } s8_type;

   typedef struct packed {
      ybox_type           ybox;
      mode_type           mode;
      lon_type            x;
      logic               xin;
      logic signed [61:0] prod;
      n_type              ns;
      dx_type             dxs;
   } s9_type;

   typedef struct packed {
      ybox_type ybox;
      mode_type mode;
      lon_type  x;
      logic     xin;
      n_type    num2;
      dx_type   dxs;
   } s10_type;

   typedef struct packed {
      logic [NUM2_W-1:0] num_mag;
      logic [DEN2_W-1:0] den_mag;
      side2_type         side;
   } s11_type;

   logic        ce;
   logic [7:0]  pre_v_ff;
   logic [3:0]  mid_v_ff;

   s0_type  s0_ff,  s0_in;
   s1_type  s1_ff,  s1_in;
   s2_type  s2_ff,  s2_in;
   s3_type  s3_ff,  s3_in;
   s4_type  s4_ff,  s4_in;
   s5_type  s5_ff,  s5_in;
   s6_type  s6_ff,  s6_in;
   s7_type  s7_ff,  s7_in;
   s8_type  s8_ff,  s8_in;
   s9_type  s9_ff,  s9_in;
   s10_type s10_ff, s10_in;
   s11_type s11_ff, s11_in;

   logic               d1_v;
   logic [QUO_W-1:0]   d1_q;
   logic               d1_ovf;
   logic [SIDE1_W-1:0] d1_side;
   side1_type          d1_s;
   logic               d2_v;
   logic [QUO_W-1:0]   d2_q;
   logic               d2_ovf;
   logic [SIDE2_W-1:0] d2_side;
   side2_type          d2_s;

   logic                  rsp_tvalid_ff;
   outcome_type           outcome_ff, outcome_in;
   lat_type               lat_ff, lat_in;
   lon_type               lon_ff, lon_in;

   // whole pipeline advances unless a result is held on the output
   assign ce         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = ce;

   always_comb begin
      s0_in = s0_type'(req_tdata[$bits(s0_type)-1:0]);
      // tdata carries the first field lowest; struct packs the first member highest
      s0_in.ax0 = $signed(req_tdata[30:0]);
      s0_in.ay0 = $signed(req_tdata[60:31]);
      s0_in.ax1 = $signed(req_tdata[91:61]);
      s0_in.ay1 = $signed(req_tdata[121:92]);
      s0_in.bx0 = $signed(req_tdata[152:122]);
      s0_in.by0 = $signed(req_tdata[182:153]);
      s0_in.bx1 = $signed(req_tdata[213:183]);
      s0_in.by1 = $signed(req_tdata[243:214]);
   end

   always_comb begin
      s1_in.dxa = DX_W'(s0_ff.ax1) - DX_W'(s0_ff.ax0);
      s1_in.dxb = DX_W'(s0_ff.bx1) - DX_W'(s0_ff.bx0);
      s1_in.dya = DY_W'(s0_ff.ay1) - DY_W'(s0_ff.ay0);
      s1_in.dyb = DY_W'(s0_ff.by1) - DY_W'(s0_ff.by0);
      s1_in.va  = s0_ff.ax1 == s0_ff.ax0;
      s1_in.vb  = s0_ff.bx1 == s0_ff.bx0;
      s1_in.ax0 = s0_ff.ax0;
      s1_in.bx0 = s0_ff.bx0;
      s1_in.ax1 = s0_ff.ax1;
      s1_in.bx1 = s0_ff.bx1;
      s1_in.ay0 = s0_ff.ay0;
      s1_in.by0 = s0_ff.by0;
      s1_in.xbox.a_lo = (s0_ff.ax0 < s0_ff.ax1) ? s0_ff.ax0 : s0_ff.ax1;
      s1_in.xbox.a_hi = (s0_ff.ax0 < s0_ff.ax1) ? s0_ff.ax1 : s0_ff.ax0;
      s1_in.xbox.b_lo = (s0_ff.bx0 < s0_ff.bx1) ? s0_ff.bx0 : s0_ff.bx1;
      s1_in.xbox.b_hi = (s0_ff.bx0 < s0_ff.bx1) ? s0_ff.bx1 : s0_ff.bx0;
      s1_in.ybox.a_lo = (s0_ff.ay0 < s0_ff.ay1) ? s0_ff.ay0 : s0_ff.ay1;
      s1_in.ybox.a_hi = (s0_ff.ay0 < s0_ff.ay1) ? s0_ff.ay1 : s0_ff.ay0;
      s1_in.ybox.b_lo = (s0_ff.by0 < s0_ff.by1) ? s0_ff.by0 : s0_ff.by1;
      s1_in.ybox.b_hi = (s0_ff.by0 < s0_ff.by1) ? s0_ff.by1 : s0_ff.by0;
   end

   always_comb begin
      s2_in.xbox = s1_ff.xbox;
      s2_in.ybox = s1_ff.ybox;
      s2_in.dxa  = s1_ff.dxa;
      s2_in.dxb  = s1_ff.dxb;
      s2_in.dya  = s1_ff.dya;
      s2_in.dyb  = s1_ff.dyb;
      s2_in.ax1  = s1_ff.ax1;
      s2_in.bx1  = s1_ff.bx1;
      s2_in.va   = s1_ff.va;
      s2_in.vb   = s1_ff.vb;
      s2_in.pa1  = 62'(s1_ff.ay0) * 62'(s1_ff.dxa);
      s2_in.pa2  = 62'(s1_ff.ax0) * 62'(s1_ff.dya);
      s2_in.pb1  = 62'(s1_ff.by0) * 62'(s1_ff.dxb);
      s2_in.pb2  = 62'(s1_ff.bx0) * 62'(s1_ff.dyb);
      s2_in.psa  = 63'(s1_ff.dya) * 63'(s1_ff.dxb);
      s2_in.psb  = 63'(s1_ff.dyb) * 63'(s1_ff.dxa);
   end

   always_comb begin
      s3_in.xbox = s2_ff.xbox;
      s3_in.ybox = s2_ff.ybox;
      s3_in.dxa  = s2_ff.dxa;
      s3_in.dxb  = s2_ff.dxb;
      s3_in.na   = N_W'(s2_ff.pa1) - N_W'(s2_ff.pa2);
      s3_in.nb   = N_W'(s2_ff.pb1) - N_W'(s2_ff.pb2);
      s3_in.den  = N_W'(s2_ff.psa) - N_W'(s2_ff.psb);
      s3_in.xv   = '0;
      s3_in.dys  = s2_ff.dya;
      s3_in.ns   = s3_in.na;
      s3_in.dxs  = s2_ff.dxa;
      priority if (s2_ff.va && s2_ff.vb) begin
         s3_in.mode = (s2_ff.ax1 == s2_ff.bx1) ? MODE_COINC : MODE_MISS;
      end else if (s2_ff.va) begin
         // y from segment B's line at A's x
         s3_in.mode = MODE_VERT;
         s3_in.xv   = s2_ff.ax1;
         s3_in.dys  = s2_ff.dyb;
         s3_in.ns   = s3_in.nb;
         s3_in.dxs  = s2_ff.dxb;
      end else if (s2_ff.vb) begin
         s3_in.mode = MODE_VERT;
         s3_in.xv   = s2_ff.bx1;
      end else if (s2_ff.psa == s2_ff.psb) begin
         s3_in.mode = MODE_PARALLEL;
      end else begin
         s3_in.mode = MODE_GENERAL;
      end
   end

   // split the intercepts so each partial product stays near 32 by 32
   always_comb begin
      s4_in.xbox = s3_ff.xbox;
      s4_in.ybox = s3_ff.ybox;
      s4_in.mode = s3_ff.mode;
      s4_in.xv   = s3_ff.xv;
      s4_in.dys  = s3_ff.dys;
      s4_in.ns   = s3_ff.ns;
      s4_in.dxs  = s3_ff.dxs;
      s4_in.den  = s3_ff.den;
      s4_in.pbh  = 64'($signed(s3_ff.nb[N_W-1:HALF_N_W])) * 64'(s3_ff.dxa);
      s4_in.pbl  = 65'($signed({1'b0, s3_ff.nb[HALF_N_W-1:0]})) * 65'(s3_ff.dxa);
      s4_in.pah  = 64'($signed(s3_ff.na[N_W-1:HALF_N_W])) * 64'(s3_ff.dxb);
      s4_in.pal  = 65'($signed({1'b0, s3_ff.na[HALF_N_W-1:0]})) * 65'(s3_ff.dxb);
   end

   always_comb begin
      s5_in.xbox  = s4_ff.xbox;
      s5_in.ybox  = s4_ff.ybox;
      s5_in.mode  = s4_ff.mode;
      s5_in.xv    = s4_ff.xv;
      s5_in.dys   = s4_ff.dys;
      s5_in.ns    = s4_ff.ns;
      s5_in.dxs   = s4_ff.dxs;
      s5_in.den   = s4_ff.den;
      s5_in.nbdxa = (NUM1_W'(s4_ff.pbh) <<< HALF_N_W) + NUM1_W'(s4_ff.pbl);
      s5_in.nadxb = (NUM1_W'(s4_ff.pah) <<< HALF_N_W) + NUM1_W'(s4_ff.pal);
   end

   always_comb begin
      s6_in.xbox = s5_ff.xbox;
      s6_in.ybox = s5_ff.ybox;
      s6_in.xv   = s5_ff.xv;
      s6_in.dys  = s5_ff.dys;
      s6_in.ns   = s5_ff.ns;
      s6_in.dxs  = s5_ff.dxs;
      s6_in.den  = s5_ff.den;
      s6_in.num  = s5_ff.nbdxa - s5_ff.nadxb;
      s6_in.mode = s5_ff.mode;
      if (s5_ff.mode == MODE_PARALLEL) begin
         s6_in.mode = (s5_ff.nbdxa == s5_ff.nadxb) ? MODE_COINC : MODE_MISS;
      end
   end

   always_comb begin
      s7_in.side.xbox = s6_ff.xbox;
      s7_in.side.ybox = s6_ff.ybox;
      s7_in.side.mode = s6_ff.mode;
      s7_in.side.xv   = s6_ff.xv;
      s7_in.side.dys  = s6_ff.dys;
      s7_in.side.ns   = s6_ff.ns;
      s7_in.side.dxs  = s6_ff.dxs;
      s7_in.side.neg  = s6_ff.num[NUM1_W-1] ^ s6_ff.den[N_W-1];
      if (s6_ff.mode == MODE_GENERAL) begin
         s7_in.num_mag = s6_ff.num[NUM1_W-1] ? NUM1_W'(-s6_ff.num) : NUM1_W'(s6_ff.num);
         s7_in.den_mag = s6_ff.den[N_W-1] ? DEN1_W'(-s6_ff.den) : DEN1_W'(s6_ff.den);
      end else begin
         // keep the divider fed with a harmless divisor
         s7_in.num_mag = '0;
         s7_in.den_mag = DEN1_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff <= '0;
      end else if (ce) begin
         pre_v_ff <= {pre_v_ff[6:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   sipu_div #(
      .NUM_W  (NUM1_W),
      .DEN_W  (DEN1_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE1_W)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (pre_v_ff[7]),
      .in_num    (s7_ff.num_mag),
      .in_den    (s7_ff.den_mag),
      .in_side   (s7_ff.side),
      .out_valid (d1_v),
      .out_q     (d1_q),
      .out_ovf   (d1_ovf),
      .out_side  (d1_side)
   );

   assign d1_s = side1_type'(d1_side);

   always_comb begin
      logic signed [X_W-1:0] xq;
      logic                  in_box;
      xq = d1_s.neg ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});
      s8_in.ybox = d1_s.ybox;
      s8_in.mode = d1_s.mode;
      s8_in.dys  = d1_s.dys;
      s8_in.ns   = d1_s.ns;
      s8_in.dxs  = d1_s.dxs;
      s8_in.x    = (d1_s.mode == MODE_VERT) ? X_W'(d1_s.xv) : xq;
      in_box = (s8_in.x >= X_W'(d1_s.xbox.a_lo)) && (s8_in.x <= X_W'(d1_s.xbox.a_hi)) &&
               (s8_in.x >= X_W'(d1_s.xbox.b_lo)) && (s8_in.x <= X_W'(d1_s.xbox.b_hi));
      s8_in.xin = in_box && !((d1_s.mode == MODE_GENERAL) && d1_ovf);
   end

   always_comb begin
      s9_in.ybox = s8_ff.ybox;
      s9_in.mode = s8_ff.mode;
      s9_in.x    = $signed(s8_ff.x[LON_W-1:0]);
      s9_in.xin  = s8_ff.xin;
      s9_in.ns   = s8_ff.ns;
      s9_in.dxs  = s8_ff.dxs;
      s9_in.prod = 62'(s8_ff.dys) * 62'($signed(s8_ff.x[LON_W-1:0]));
   end

   always_comb begin
      s10_in.ybox = s9_ff.ybox;
      s10_in.mode = s9_ff.mode;
      s10_in.x    = s9_ff.x;
      s10_in.xin  = s9_ff.xin;
      s10_in.dxs  = s9_ff.dxs;
      s10_in.num2 = N_W'(s9_ff.prod) + s9_ff.ns;
   end

   always_comb begin
      logic act;
      act = ((s10_ff.mode == MODE_VERT) || (s10_ff.mode == MODE_GENERAL)) && s10_ff.xin;
      s11_in.side.ybox = s10_ff.ybox;
      s11_in.side.mode = s10_ff.mode;
      s11_in.side.x    = s10_ff.x;
      s11_in.side.xin  = act;
      s11_in.side.neg  = s10_ff.num2[N_W-1] ^ s10_ff.dxs[DX_W-1];
      if (act) begin
         s11_in.num_mag = s10_ff.num2[N_W-1] ? NUM2_W'(-s10_ff.num2) : NUM2_W'(s10_ff.num2);
         s11_in.den_mag = s10_ff.dxs[DX_W-1] ? DEN2_W'(-s10_ff.dxs) : DEN2_W'(s10_ff.dxs);
      end else begin
         s11_in.num_mag = '0;
         s11_in.den_mag = DEN2_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_v_ff <= '0;
      end else if (ce) begin
         mid_v_ff <= {mid_v_ff[2:0], d1_v};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
      end
   end

   sipu_div #(
      .NUM_W  (NUM2_W),
      .DEN_W  (DEN2_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE2_W)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (mid_v_ff[3]),
      .in_num    (s11_ff.num_mag),
      .in_den    (s11_ff.den_mag),
      .in_side   (s11_ff.side),
      .out_valid (d2_v),
      .out_q     (d2_q),
      .out_ovf   (d2_ovf),
      .out_side  (d2_side)
   );

   assign d2_s = side2_type'(d2_side);

   always_comb begin
      logic signed [X_W-1:0] y;
      logic                  ok;
      y  = d2_s.neg ? -$signed({1'b0, d2_q}) : $signed({1'b0, d2_q});
      ok = d2_s.xin && !d2_ovf &&
           (y >= X_W'(d2_s.ybox.a_lo)) && (y <= X_W'(d2_s.ybox.a_hi)) &&
           (y >= X_W'(d2_s.ybox.b_lo)) && (y <= X_W'(d2_s.ybox.b_hi));
      if (ok) begin
         outcome_in = OUT_CROSS;
         lat_in     = $signed(y[LAT_W-1:0]);
         lon_in     = d2_s.x;
      end else begin
         outcome_in = (d2_s.mode == MODE_COINC) ? OUT_COINC : OUT_NONE;
         lat_in     = '0;
         lon_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (ce) begin
         rsp_tvalid_ff <= d2_v;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         outcome_ff <= outcome_in;
         lat_ff     <= lat_in;
         lon_ff     <= lon_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, lon_ff, lat_ff};
   assign rsp_tuser  = outcome_ff;

`ifndef NO_ASSERTIONS
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == OUT_NONE || rsp_tuser == OUT_CROSS ||
                      rsp_tuser == OUT_COINC))
      else $error("invalid outcome code on rsp");

   a_zero_when_no_cross: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != OUT_CROSS) |-> (rsp_tdata == '0))
      else $error("coordinates not cleared on non-crossing result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && pre_v_ff == '0 && mid_v_ff == '0))
      else $error("pipeline valid bits survive reset");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !ce |=> ($stable(pre_v_ff) && $stable(mid_v_ff)))
      else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/segment_intersection_point_unit_tb.sv =====
// Self-checking testbench of the segment intersection point unit: directed and random pairs.
// Depends on sipu_pkg and the segment_intersection_point_unit RTL; predicts each result itself.
module segment_intersection_point_unit_tb;
   import sipu_pkg::*;

   localparam int HOLD_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1430;
   localparam int PAUSE_AT = 700;
   localparam int TAIL_CYCLES = 120;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      lon_type ax0;
      lat_type ay0;
      lon_type ax1;
      lat_type ay1;
      lon_type bx0;
      lat_type by0;
      lon_type bx1;
      lat_type by1;
   } seg_pair_type;

   typedef struct {
      outcome_type outcome;
      lat_type     lat;
      lon_type     lon;
   } crossing_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [OUT_W-1:0] rsp_tuser;

   seg_pair_type pending_pairs[$];
   crossing_type expected_crossings[$];
   int mismatches = 0;
   int sent_pairs = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int stall_left = 0;

   segment_intersection_point_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit span_has(longint v, longint p, longint r);
      longint lo, hi;
      lo = (p < r) ? p : r;
      hi = (p < r) ? r : p;
      return lo <= v && v <= hi;
   endfunction

   function automatic crossing_type intersect_segments(seg_pair_type s);
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      longint dxa, dya, dxb, dyb, na, nb, den, x, y;
      wide_type lhs, rhs, num, quo;
      bit have;
      crossing_type res;
      ax0 = s.ax0; ay0 = s.ay0; ax1 = s.ax1; ay1 = s.ay1;
      bx0 = s.bx0; by0 = s.by0; bx1 = s.bx1; by1 = s.by1;
      dxa = ax1 - ax0; dya = ay1 - ay0;
      dxb = bx1 - bx0; dyb = by1 - by0;
      na = ay0 * dxa - ax0 * dya;
      nb = by0 * dxb - bx0 * dyb;
      x = 0;
      y = 0;
      have = 1'b0;
      res.outcome = OUT_NONE;
      if (dxa == 0 && dxb == 0) begin
         res.outcome = (ax1 == bx1) ? OUT_COINC : OUT_NONE;
      end else if (dxa == 0) begin
         x = ax1;
         y = (dyb * x + nb) / dxb;
         have = 1'b1;
      end else if (dxb == 0) begin
         x = bx1;
         y = (dya * x + na) / dxa;
         have = 1'b1;
      end else if (dya * dxb == dyb * dxa) begin
         lhs = wide_type'(na) * wide_type'(dxb);
         rhs = wide_type'(nb) * wide_type'(dxa);
         res.outcome = (lhs == rhs) ? OUT_COINC : OUT_NONE;
      end else begin
         num = wide_type'(nb) * wide_type'(dxa) - wide_type'(na) * wide_type'(dxb);
         den = dya * dxb - dyb * dxa;
         quo = num / wide_type'(den);
         // a quotient beyond 2^31 in magnitude can never land in a box
         if (quo <= 128'sd2147483648 && quo >= -128'sd2147483648 &&
             span_has(longint'(quo), ax0, ax1) && span_has(longint'(quo), bx0, bx1)) begin
            x = longint'(quo);
            y = (dya * x + na) / dxa;
            have = 1'b1;
         end
      end
      if (have && span_has(x, ax0, ax1) && span_has(x, bx0, bx1) &&
          span_has(y, ay0, ay1) && span_has(y, by0, by1)) begin
         res.outcome = OUT_CROSS;
         res.lat = lat_type'(y);
         res.lon = lon_type'(x);
      end else begin
         res.lat = '0;
         res.lon = '0;
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic longint rand_span(longint lim);
      return longint'($urandom_range(32'(2 * lim), 0)) - lim;
   endfunction

   function automatic seg_pair_type make_pair(longint ax0, longint ay0, longint ax1,
                                              longint ay1, longint bx0, longint by0,
                                              longint bx1, longint by1);
      seg_pair_type p;
      p.ax0 = lon_type'(ax0); p.ay0 = lat_type'(ay0);
      p.ax1 = lon_type'(ax1); p.ay1 = lat_type'(ay1);
      p.bx0 = lon_type'(bx0); p.by0 = lat_type'(by0);
      p.bx1 = lon_type'(bx1); p.by1 = lat_type'(by1);
      return p;
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type p;
      longint cx, cy, rad, dx, dy, t, u, lonlim, latlim;
      int kind;
      kind = $urandom_range(9, 0);
      lonlim = 754974720;
      latlim = 377487360;
      if (kind < 3) begin
         // raw bit patterns, out of range included
         p = make_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 5) begin
         dx = rand_span(1000);
         dy = rand_span(1000);
         cx = rand_span(lonlim / 2);
         cy = rand_span(latlim / 2);
         t = rand_span(3);
         u = rand_span(3);
         // collinear pieces, sometimes nudged off the line
         p = make_pair(cx, cy, cx + 2 * dx, cy + 2 * dy, cx + t * dx, cy + t * dy,
                       cx + u * dx, cy + u * dy + ($urandom_range(3, 0) == 0));
      end else begin
         rad = ($urandom_range(3, 0) == 0) ? lonlim / 2 : 64 << $urandom_range(16, 0);
         cx = rand_span(lonlim - rad);
         cy = rand_span(latlim - rad / 2);
         p = make_pair(cx + rand_span(rad), cy + rand_span(rad / 2),
                       cx + rand_span(rad), cy + rand_span(rad / 2),
                       cx + rand_span(rad), cy + rand_span(rad / 2),
                       cx + rand_span(rad), cy + rand_span(rad / 2));
         if ($urandom_range(5, 0) == 0) p.ax1 = p.ax0;
         if ($urandom_range(5, 0) == 0) p.bx1 = p.bx0;
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   initial begin
      longint xl, yl;
      xl = 754974720;
      yl = 377487360;
      // both vertical, same and different longitude
      pending_pairs.push_back(make_pair(5, 0, 5, 100, 5, 50, 5, 300));
      pending_pairs.push_back(make_pair(5, 0, 5, 100, 6, 0, 6, 100));
      // one vertical crossing the other, and missing it
      pending_pairs.push_back(make_pair(10, -50, 10, 50, 0, 0, 20, 10));
      pending_pairs.push_back(make_pair(0, 0, 20, 10, 10, -50, 10, 50));
      pending_pairs.push_back(make_pair(10, 50, 10, 60, 0, 0, 20, 10));
      // parallel coincident, parallel apart, anti-direction coincident
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 20, 20, 30, 30));
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 1, 10, 11));
      pending_pairs.push_back(make_pair(0, 0, 10, -10, 30, -30, 20, -20));
      // general crossing, crossing outside the boxes, touching at an end
      pending_pairs.push_back(make_pair(-100, -100, 100, 100, -100, 100, 100, -100));
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 100, 0, 90, 3));
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 10, 10, 20, 0));
      // truncation toward zero with negative quotient
      pending_pairs.push_back(make_pair(-7, -3, 5, 2, -6, 4, 3, -5));
      // point segments
      pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
      pending_pairs.push_back(make_pair(3, 3, 3, 3, 3, 3, 3, 3));
      // full-range diagonals and extremes
      pending_pairs.push_back(make_pair(-xl, -yl, xl, yl, -xl, yl, xl, -yl));
      pending_pairs.push_back(make_pair(xl, yl, -xl, -yl, xl, -yl, -xl, yl));
      pending_pairs.push_back(make_pair(-xl, -yl, xl, -yl, -xl, yl, xl, yl));
      pending_pairs.push_back(make_pair(-xl, -yl, xl, yl - 1, -xl + 1, -yl, xl, yl));
      pending_pairs.push_back(make_pair(-(64'd1 << 30), -(64'd1 << 29), (64'd1 << 30) - 1,
                                        (64'd1 << 29) - 1, (64'd1 << 30) - 1, -(64'd1 << 29),
                                        -(64'd1 << 30), (64'd1 << 29) - 1));
      pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(-(64'd1 << 30), 0, (64'd1 << 30) - 1, 0,
                                        0, -(64'd1 << 29), 0, (64'd1 << 29) - 1));
      repeat (RANDOM_ITEMS) pending_pairs.push_back(random_pair());

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_pairs.size() == 0 && !req_tvalid);
      wait (expected_crossings.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_crossings.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // driver
   always @(posedge clock) begin
      seg_pair_type p;
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_crossings.push_back(intersect_segments(pending_pairs.pop_front()));
            sent_pairs++;
            send_gap = pick_gap();
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (sent_pairs == PAUSE_AT && expected_crossings.size() != 0) begin
               // hold off until the pipeline has drained
            end else if (pending_pairs.size() != 0) begin
               p = pending_pairs[0];
               req_tdata <= {4'b0, p.by1, p.bx1, p.by0, p.bx0, p.ay1, p.ax1, p.ay0, p.ax0};
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      crossing_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_crossings.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tuser, 0);
            end else begin
               want = expected_crossings.pop_front();
               if (rsp_tuser !== want.outcome)
                  report_mismatch("outcome", rsp_tuser, want.outcome);
               if (rsp_tdata[LAT_W-1:0] !== want.lat)
                  report_mismatch("cross_lat", lat_type'(rsp_tdata[LAT_W-1:0]), want.lat);
               if (rsp_tdata[LAT_W+LON_W-1:LAT_W] !== want.lon)
                  report_mismatch("cross_lon", lon_type'(rsp_tdata[LAT_W+LON_W-1:LAT_W]),
                                  want.lon);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HOLD_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
design/sipu_pkg.sv
design/sipu_div.sv
design/segment_intersection_point_unit.sv
tb/sv/segment_intersection_point_unit_tb.sv
